/* rtl/nmec_pkg.sv */
// ---------------------------------------------------------------------------
// nmec_pkg
// Shared constants and types for the 3x3 neighbour mask edge classifier.
// ---------------------------------------------------------------------------
package nmec_pkg;

	localparam int GRID_SIDE = 256;
	localparam int COORD_W   = $clog2(GRID_SIDE);
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

	localparam logic [7:0] FULL_MASK = 8'hFF;

	typedef logic [COORD_W-1:0] coord_t;

	// one result word as it travels to the output queue
	typedef struct packed {
		logic       is_fill;
		logic [7:0] cell_x;
		logic [7:0] cell_y;
		logic [7:0] neighbour_mask;
		logic [3:0] sprite_col;
		logic [3:0] sprite_row;
	} res_t;

	// line memory write request
	typedef struct packed {
		logic       we;
		coord_t     addr;
		logic [1:0] data;
	} lb_wr_t;

endpackage

/* rtl/nmec_line_ram.sv */
// ---------------------------------------------------------------------------
// nmec_line_ram
// Line memory for the two previous rows: bit 1 is the row two above,
// bit 0 the row just above. One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module nmec_line_ram
	import nmec_pkg::*;
(
	input  logic       clk,
	input  logic       rd_en,
	input  coord_t     rd_addr,
	output logic [1:0] rd_data,
	input  lb_wr_t     wr
);

	logic [1:0] mem [GRID_SIDE];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/nmec_out_fifo.sv */
// ---------------------------------------------------------------------------
// nmec_out_fifo
// Small result queue that decouples the classifier pipe from the consumer.
// ---------------------------------------------------------------------------
module nmec_out_fifo
	import nmec_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  res_t                 push_data,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output res_t                 pop_data,
	output logic [OUT_PTR_W:0]   count
);

	res_t                 buf_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [OUT_PTR_W:0]   count_q;
	logic                 pop;

	assign pop_valid = (count_q != '0);
	assign pop       = pop_valid && pop_ready;
	assign pop_data  = buf_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/neighbour_mask_edge_classifier_top.sv */
// ---------------------------------------------------------------------------
// neighbour_mask_edge_classifier_top
// Raster 3x3 neighbour mask classifier with line memory and result queue.
// ---------------------------------------------------------------------------
// Takes one cell word per clock in raster order over a GRID_SIDE square grid
// and emits a word for every set interior centre, on the cycle after the word
// carrying its bottom-right neighbour has passed the line memory read. An
// item reaches the result queue on the edge after the one that accepts it: the
// accepting edge performs the registered read of the line memory, the next
// edge the window update, the write-back and the push. Sustained rate is one
// cell per clock while the consumer keeps up; cell_ready drops only when the
// four-entry result queue plus the word in flight would overflow. Line memory
// needs no clearing after reset.
module neighbour_mask_edge_classifier_top
	import nmec_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	input  logic       cell_valid,
	output logic       cell_ready,
	input  logic [1:0] cell_level,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       is_fill,
	output logic [7:0] cell_x,
	output logic [7:0] cell_y,
	output logic [7:0] neighbour_mask,
	output logic [3:0] sprite_col,
	output logic [3:0] sprite_row
);

	logic [1:0]         level_threshold_q;
	coord_t             col_q;
	coord_t             row_q;
	logic               accept;

	logic               valid_s1;
	logic [1:0]         level_s1;
	coord_t             x_s1;
	coord_t             y_s1;
	logic [1:0]         rd_data;

	logic [8:0]         window_q;
	logic [8:0]         window_nxt;
	logic               set_bit;
	logic [7:0]         mask;
	logic               res_hit;
	res_t               res;
	lb_wr_t             lb_wr;
	res_t               head;
	logic [OUT_PTR_W:0] occ;
	logic [COORD_W+7:0] x_wide;
	logic [COORD_W+7:0] y_wide;

	assign accept     = cell_valid && cell_ready;
	// room for the word in s1 and the one being taken now
	assign cell_ready = ({1'b0, occ} + {{(OUT_PTR_W+1){1'b0}}, valid_s1})
			<= (OUT_PTR_W+2)'(OUT_DEPTH - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_threshold_q <= 2'd1;
		end else if (cfg_we) begin
			level_threshold_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_q == COORD_W'(GRID_SIDE - 1)) begin
				col_q <= '0;
				if (row_q == COORD_W'(GRID_SIDE - 1)) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			level_s1 <= cell_level;
			x_s1     <= col_q;
			y_s1     <= row_q;
		end
	end

	// write-back always targets the previous column, so a read never meets
	// a pending write to the same entry
	nmec_line_ram u_line_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (rd_data),
		.wr      (lb_wr)
	);

	assign set_bit = (level_s1 >= level_threshold_q);

	always_comb begin
		window_nxt[2:0] = {rd_data[1], window_q[2:1]};
		window_nxt[5:3] = {rd_data[0], window_q[5:4]};
		window_nxt[8:6] = {set_bit, window_q[8:7]};
	end

	assign lb_wr.we   = valid_s1;
	assign lb_wr.addr = x_s1;
	assign lb_wr.data = {rd_data[0], set_bit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (valid_s1) begin
			window_q <= window_nxt;
		end
	end

	// bit 0 to bit 7: t, tr, r, br, b, bl, l, tl
	assign mask = {window_nxt[0], window_nxt[3], window_nxt[6], window_nxt[7],
			window_nxt[8], window_nxt[5], window_nxt[2], window_nxt[1]};

	assign res_hit = valid_s1 && (x_s1 >= COORD_W'(2)) && (y_s1 >= COORD_W'(2))
			&& window_nxt[4];

	assign x_wide = {8'd0, x_s1 - 1'b1};
	assign y_wide = {8'd0, y_s1 - 1'b1};

	always_comb begin
		res.cell_x         = x_wide[7:0];
		res.cell_y         = y_wide[7:0];
		res.neighbour_mask = mask;
		res.is_fill        = (mask == FULL_MASK);
		if (res.is_fill) begin
			res.sprite_col = 4'd0;
			res.sprite_row = 4'd0;
		end else begin
			res.sprite_col = mask[3:0];
			res.sprite_row = ~mask[7:4];
		end
	end

	nmec_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_hit),
		.push_data (res),
		.pop_valid (out_valid),
		.pop_ready (out_ready),
		.pop_data  (head),
		.count     (occ)
	);

	assign is_fill        = head.is_fill;
	assign cell_x         = head.cell_x;
	assign cell_y         = head.cell_y;
	assign neighbour_mask = head.neighbour_mask;
	assign sprite_col     = head.sprite_col;
	assign sprite_row     = head.sprite_row;

endmodule

/* rtl/nmec_checker.sv */
// ---------------------------------------------------------------------------
// nmec_checker
// Port-level checks for the neighbour mask edge classifier.
// ---------------------------------------------------------------------------
module nmec_checker
	import nmec_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       is_fill,
	input logic [7:0] cell_x,
	input logic [7:0] neighbour_mask,
	input logic [3:0] sprite_col,
	input logic [3:0] sprite_row
);

	// a stalled word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(neighbour_mask))
		else $error("output word dropped or changed while stalled");

	a_fill_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_fill == (neighbour_mask == FULL_MASK)))
		else $error("fill flag disagrees with mask");

	a_fill_sprite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_fill |-> sprite_col == 4'd0 && sprite_row == 4'd0)
		else $error("fill word carries a sprite index");

	a_edge_sprite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_fill |->
			sprite_col == neighbour_mask[3:0] && sprite_row == ~neighbour_mask[7:4])
		else $error("edge sprite index does not match mask");

	a_border_x: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (GRID_SIDE == 256) |-> cell_x != 8'd0 && cell_x != 8'd255)
		else $error("border column produced a word");

endmodule

bind neighbour_mask_edge_classifier_top nmec_checker u_nmec_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.is_fill        (is_fill),
	.cell_x         (cell_x),
	.neighbour_mask (neighbour_mask),
	.sprite_col     (sprite_col),
	.sprite_row     (sprite_row)
);
